// File: sv/kps_pkg.sv
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types, constants and the hex segment decode for the keypad scanner.
// ----------------------------------------------------------------------------
package kps_pkg;

  // scan phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CONFIRM = 3'd1,
    PH_PROBE   = 3'd2,
    PH_ROWWAIT = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  localparam int unsigned CNT_W    = 16;
  localparam logic [15:0] CNT_MAX  = 16'hffff;
  localparam logic [15:0] DEB_RST  = 16'd10;
  localparam logic [3:0]  COLS_OFF = 4'hf;
  localparam logic [1:0]  ROW_LAST = 2'd3;

  // single low column codes
  localparam logic [3:0] COL0_LOW = 4'he;
  localparam logic [3:0] COL1_LOW = 4'hd;
  localparam logic [3:0] COL2_LOW = 4'hb;
  localparam logic [3:0] COL3_LOW = 4'h7;

  // scanner state carried between items
  typedef struct packed {
    phase_t           phase;
    logic [1:0]       row;
    logic [CNT_W-1:0] wait_cnt;
    logic [3:0]       held_key;
  } scan_state_t;

  // one result item
  typedef struct packed {
    logic [7:0] segments;
    logic       key_new;
    logic [3:0] key_code;
    logic [3:0] row_drive;
  } scan_result_t;

  // common-anode hex digit pattern, active low
  function automatic logic [7:0] seg_decode(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'h0: seg = 8'hc0;
      4'h1: seg = 8'hf9;
      4'h2: seg = 8'ha4;
      4'h3: seg = 8'hb0;
      4'h4: seg = 8'h99;
      4'h5: seg = 8'h92;
      4'h6: seg = 8'h82;
      4'h7: seg = 8'hf8;
      4'h8: seg = 8'h80;
      4'h9: seg = 8'h90;
      4'ha: seg = 8'h88;
      4'hb: seg = 8'h83;
      4'hc: seg = 8'ha7;
      4'hd: seg = 8'ha1;
      4'he: seg = 8'h86;
      4'hf: seg = 8'h8e;
      default: seg = 8'hff;
    endcase
    return seg;
  endfunction

endpackage

// File: sv/kps_step.sv
// ----------------------------------------------------------------------------
// kps_step
// Next-state and result logic of the scanner for one column sample.
// ----------------------------------------------------------------------------
module kps_step (
  input  kps_pkg::scan_state_t  cur,
  input  logic [3:0]            cols,
  input  logic [15:0]           debounce_ticks,
  output kps_pkg::scan_state_t  nxt,
  output kps_pkg::scan_result_t res
);
  import kps_pkg::*;

  logic             pressed;
  logic [15:0]      limit;
  logic [CNT_W-1:0] cnt_inc;
  logic             wait_done;
  logic             single;
  logic [1:0]       col_idx;
  logic             fresh;

  assign pressed = (cols != COLS_OFF);
  assign limit   = (debounce_ticks == '0) ? 16'd1 : debounce_ticks;
  assign cnt_inc = (cur.wait_cnt < CNT_MAX) ? cur.wait_cnt + 16'd1 : cur.wait_cnt;
  assign wait_done = (cnt_inc >= limit);

  // single low column decode
  always_comb begin
    single  = 1'b1;
    col_idx = 2'd0;
    case (cols)
      COL0_LOW: col_idx = 2'd0;
      COL1_LOW: col_idx = 2'd1;
      COL2_LOW: col_idx = 2'd2;
      COL3_LOW: col_idx = 2'd3;
      default:  single  = 1'b0;
    endcase
  end

  // phase transitions
  always_comb begin
    nxt   = cur;
    fresh = 1'b0;
    case (cur.phase)
      PH_IDLE: begin
        if (pressed) begin
          nxt.phase    = PH_CONFIRM;
          nxt.wait_cnt = '0;
        end
      end
      PH_CONFIRM: begin
        nxt.wait_cnt = cnt_inc;
        if (wait_done) begin
          if (pressed) begin
            nxt.row   = 2'd0;
            nxt.phase = PH_PROBE;
          end else begin
            nxt.phase = PH_IDLE;
          end
        end
      end
      PH_PROBE: begin
        if (pressed) begin
          nxt.phase    = PH_ROWWAIT;
          nxt.wait_cnt = '0;
        end else if (cur.row != ROW_LAST) begin
          nxt.row = cur.row + 2'd1;
        end else begin
          nxt.row   = 2'd0;
          nxt.phase = PH_IDLE;
        end
      end
      PH_ROWWAIT: begin
        nxt.wait_cnt = cnt_inc;
        if (wait_done) begin
          if (pressed) begin
            if (single) begin
              nxt.held_key = {cur.row, col_idx};
              fresh        = 1'b1;
            end
            nxt.phase = PH_RELEASE;
          end else if (cur.row != ROW_LAST) begin
            nxt.row   = cur.row + 2'd1;
            nxt.phase = PH_PROBE;
          end else begin
            nxt.row   = 2'd0;
            nxt.phase = PH_IDLE;
          end
        end
      end
      PH_RELEASE: begin
        if (!pressed) begin
          if (cur.row != ROW_LAST) begin
            nxt.row   = cur.row + 2'd1;
            nxt.phase = PH_PROBE;
          end else begin
            nxt.row   = 2'd0;
            nxt.phase = PH_IDLE;
          end
        end
      end
      default: begin
        nxt.phase = PH_IDLE;
        nxt.row   = 2'd0;
      end
    endcase
  end

  // result fields from the new state
  always_comb begin
    if (nxt.phase == PH_IDLE || nxt.phase == PH_CONFIRM) begin
      res.row_drive = 4'h0;
    end else begin
      res.row_drive = ~(4'b0001 << nxt.row);
    end
    res.key_code = nxt.held_key;
    res.key_new  = fresh;
    res.segments = seg_decode(nxt.held_key);
  end

endmodule

// File: sv/matrix_keypad_scanner.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// 4x4 keypad scanner with tick-counted debounce and hex segment output.
// ----------------------------------------------------------------------------
// flow: an accepted input item is held in the input register and moves to the
//   result register when that is empty or being read out
// throughput: one item per cycle unless out_tready stalls; the scan state updates
//   as an item leaves the input register for the result register
// reset: rst_n synchronous active low; scanner idle, row 0, held key 0,
//   debounce_ticks back to 10, both item registers empty
module matrix_keypad_scanner (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] column_sense, [7:4] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] row_drive, [7:4] key_code,
                                  // [8] key_new, [16:9] segments, [23:17] zero
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // debounce_ticks
);
  import kps_pkg::*;

  logic         in_valid_r;
  logic [3:0]   cols_r;
  logic         out_valid_r;
  scan_result_t res_r;
  scan_state_t  state_r;
  logic [15:0]  deb_r;

  scan_state_t  state_nxt;
  scan_result_t res_nxt;
  logic         advance;

  // handshake
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= DEB_RST;
    end else if (cfg_valid) begin
      deb_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cols_r <= in_tdata[3:0];
    end
  end

  // step logic
  kps_step u_step (
    .cur            (state_r),
    .cols           (cols_r),
    .debounce_ticks (deb_r),
    .nxt            (state_nxt),
    .res            (res_nxt)
  );

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase    <= PH_IDLE;
      state_r.row      <= 2'd0;
      state_r.wait_cnt <= '0;
      state_r.held_key <= 4'd0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r};

endmodule

// File: bench/matrix_keypad_scanner_test.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_test
// Self-checking bench for the 4x4 keypad scanner. A virtual keypad answers
// the row drive of the previous result item with column lines, a scanner
// model predicts every result item, and a monitor compares each field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_keypad_scanner_test;
  import kps_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_AT        = 40;
  localparam int unsigned HOLD_LEN       = 80;
  localparam int unsigned MAX_REPORTS    = 10;

  // common-anode hex digits, active low
  localparam logic [7:0] HEX_SEG [16] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
    8'h80, 8'h90, 8'h88, 8'h83, 8'ha7, 8'ha1, 8'h86, 8'h8e
  };

  // walk through every scan phase with a one-tick debounce
  localparam int unsigned WALK_LEN = 23;
  localparam logic [3:0] WALK_COLS [WALK_LEN] = '{
    4'hf, 4'h0, 4'h0, 4'h7, 4'h3, 4'h3, 4'hf, 4'he, 4'he, 4'hf, 4'hf, 4'hd,
    4'hf, 4'hb, 4'hf, 4'h7, 4'h7, 4'hf, 4'hf, 4'hf, 4'h7, 4'h7, 4'hf
  };

  // one pending item: pressed keys seen through the rows, or raw column lines
  typedef struct packed {
    logic        from_pad;
    logic [15:0] keys;
    logic [3:0]  raw;
  } pad_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  pad_item_t    pending_items[$];
  scan_result_t expected_results[$];

  // scanner model state
  phase_t      sc_phase = PH_IDLE;
  logic [1:0]  sc_row = '0;
  logic [15:0] sc_wait = '0;
  logic [3:0]  sc_key = '0;
  logic [15:0] debounce = DEB_RST;
  logic [3:0]  pad_drive = '0;

  int unsigned failures = 0;
  int unsigned send_gap = 0;
  bit          send_calm = 1'b0;
  int unsigned recv_gap = 0;
  bit          recv_calm = 1'b0;
  int unsigned hold_left = 0;
  int unsigned results_taken = 0;
  int unsigned idle_cycles = 0;

  matrix_keypad_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one debounce tick, saturating; zero debounce acts as one
  function automatic logic wait_over();
    logic [15:0] lim;
    lim = (debounce == '0) ? 16'd1 : debounce;
    if (sc_wait != CNT_MAX) sc_wait = sc_wait + 16'd1;
    return sc_wait >= lim;
  endfunction

  // move on to the next row, back to idle after the last one
  function automatic void step_row();
    if (sc_row != ROW_LAST) begin
      sc_row = sc_row + 2'd1;
      sc_phase = PH_PROBE;
    end else begin
      sc_row = '0;
      sc_phase = PH_IDLE;
    end
  endfunction

  // scanner model: one column sample in, one result item expected
  task automatic advance_scanner(input logic [3:0] cols);
    logic         pressed;
    logic         fresh;
    logic         col_hit;
    logic [1:0]   col;
    scan_result_t res;
    pressed = (cols != COLS_OFF);
    fresh = 1'b0;
    col_hit = 1'b1;
    col = '0;
    case (sc_phase)
      PH_IDLE: begin
        if (pressed) begin
          sc_phase = PH_CONFIRM;
          sc_wait = '0;
        end
      end
      PH_CONFIRM: begin
        if (wait_over()) begin
          sc_row = '0;
          sc_phase = pressed ? PH_PROBE : PH_IDLE;
        end
      end
      PH_PROBE: begin
        if (pressed) begin
          sc_phase = PH_ROWWAIT;
          sc_wait = '0;
        end else begin
          step_row();
        end
      end
      PH_ROWWAIT: begin
        if (wait_over()) begin
          if (pressed) begin
            case (cols)
              COL0_LOW: col = 2'd0;
              COL1_LOW: col = 2'd1;
              COL2_LOW: col = 2'd2;
              COL3_LOW: col = 2'd3;
              default:  col_hit = 1'b0;
            endcase
            if (col_hit) begin
              sc_key = {sc_row, col};
              fresh = 1'b1;
            end
            sc_phase = PH_RELEASE;
          end else begin
            step_row();
          end
        end
      end
      PH_RELEASE: begin
        if (!pressed) step_row();
      end
      default: begin
        sc_phase = PH_IDLE;
        sc_row = '0;
      end
    endcase
    if (sc_phase == PH_IDLE || sc_phase == PH_CONFIRM) pad_drive = '0;
    else pad_drive = ~(4'b0001 << sc_row);
    res.row_drive = pad_drive;
    res.key_code = sc_key;
    res.key_new = fresh;
    res.segments = HEX_SEG[sc_key];
    expected_results.push_back(res);
  endtask

  // columns pulled low by pressed keys on driven rows
  function automatic logic [3:0] sensed_columns(input pad_item_t it, input logic [3:0] drive);
    logic [3:0] cols;
    if (!it.from_pad) return it.raw;
    cols = COLS_OFF;
    for (int r = 0; r < 4; r++) begin
      if (drive == '0 || !drive[r]) begin
        for (int c = 0; c < 4; c++) begin
          if (it.keys[4*r+c]) cols[c] = 1'b0;
        end
      end
    end
    return cols;
  endfunction

  function automatic void push_item(input logic from_pad, input logic [15:0] keys,
                                    input logic [3:0] raw);
    pad_item_t it;
    it.from_pad = from_pad;
    it.keys = keys;
    it.raw = raw;
    pending_items.push_back(it);
  endfunction

  // random key presses: mostly clean single keys, some double keys and bounce
  task automatic add_presses(input int unsigned deb, input int unsigned n);
    int unsigned cnt;
    int unsigned kind;
    int unsigned len;
    int unsigned lim;
    logic [15:0] keys;
    lim = (deb == 0) ? 1 : deb;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(0, 9);
      keys = 16'h0001 << $urandom_range(0, 15);
      if (kind == 7) keys = keys | (16'h0001 << $urandom_range(0, 15));
      if (kind >= 8) begin
        len = $urandom_range(1, 5);
        repeat (len) push_item(1'b0, '0, 4'($urandom_range(0, 15)));
        cnt += len;
      end
      if (kind != 8) begin
        len = $urandom_range(1, 4 * (lim + 2) + 6);
        repeat (len) push_item(1'b1, keys, COLS_OFF);
        cnt += len;
      end
      len = $urandom_range(1, lim + 4);
      repeat (len) push_item(1'b1, '0, COLS_OFF);
      cnt += len;
    end
  endtask

  // wait until every item is in and every result is out
  task automatic settle();
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    debounce = value;
  endtask

  task automatic note_failure(input string what, input scan_result_t want,
                              input scan_result_t got);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $write("%0t: %s: expected drive %h key %h new %b seg %h, ",
             $realtime, what, want.row_drive, want.key_code, want.key_new, want.segments);
      $display("got drive %h key %h new %b seg %h",
               got.row_drive, got.key_code, got.key_new, got.segments);
    end
  endtask

  // driver: feeds pending items, columns follow the latest predicted row drive
  always @(posedge clk) begin
    pad_item_t cur;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) advance_scanner(in_tdata[3:0]);
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur = pending_items.pop_front();
          in_tdata <= {4'h0, sensed_columns(cur, pad_drive)};
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 3);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result item and paces the result side
  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = scan_result_t'(out_tdata[16:0]);
        if (expected_results.size() == 0) begin
          note_failure("result item with nothing expected", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.row_drive !== want.row_drive || got.key_code !== want.key_code ||
              got.key_new !== want.key_new || got.segments !== want.segments ||
              out_tdata[23:17] !== '0)
            note_failure("result item mismatch", want, got);
        end
        results_taken++;
        if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
        recv_gap = recv_calm ? 0 : $urandom_range(0, 3);
        if (results_taken == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned mid_deb;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset debounce value
    add_presses(DEB_RST, 100);
    settle();

    // zero debounce: flush to idle, then walk all phases
    write_debounce(16'h0000);
    repeat (12) push_item(1'b0, '0, COLS_OFF);
    for (int i = 0; i < WALK_LEN; i++) push_item(1'b0, '0, WALK_COLS[i]);
    add_presses(0, 80);
    settle();

    write_debounce(16'h0001);
    add_presses(1, 100);
    settle();

    mid_deb = $urandom_range(2, 20);
    write_debounce(16'(mid_deb));
    add_presses(mid_deb, 100);
    repeat (4 * (mid_deb + 2) + 4) push_item(1'b1, '0, COLS_OFF);
    settle();

    // longest debounce: the confirm wait outlasts the press and carries
    // over into the next debounce setting
    write_debounce(CNT_MAX);
    repeat (40) push_item(1'b1, 16'h0001 << $urandom_range(0, 3), COLS_OFF);
    repeat (20) push_item(1'b1, '0, COLS_OFF);
    settle();

    write_debounce(16'h0003);
    add_presses(3, 100);
    settle();

    repeat (4) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: matrix_keypad_scanner.f
sv/kps_pkg.sv
sv/kps_step.sv
sv/matrix_keypad_scanner.sv
bench/matrix_keypad_scanner_test.sv
